// File: rtl/sulc_pkg.sv
// Shared types and constants for the strict single-line UTF-8 checker.
// Holds the per-byte class item, error codes and the code point screen.
// No dependencies.
package sulc_pkg;

    // error codes reported with each verdict
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_MALFORMED = 3'd2,
        ERR_CONTROL   = 3'd3,
        ERR_SPACE     = 3'd4,
        ERR_RELATIVE  = 3'd5
    } t_err;

    // check modes of the mode register
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_TOKEN = 2'd1;
    localparam logic [1:0] MODE_PATH  = 2'd2;

    // byte address of the mode register
    localparam logic [1:0] ADDR_CHECK_MODE = 2'd0;

    // what a byte means when it opens a sequence
    typedef enum logic [1:0] {
        KIND_ASCII,
        KIND_LEAD,
        KIND_BAD
    } t_kind;

    // allowed range of the first continuation byte after a lead
    typedef enum logic [2:0] {
        RNG_FULL,
        RNG_E0,
        RNG_ED,
        RNG_F0,
        RNG_F4
    } t_range;

    // classified byte travelling from front to back
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       empty_text;
        t_kind      kind;
        logic [1:0] lead_len;
        logic [4:0] lead_bits;
        t_range     range;
        logic       ascii_ctrl;
        logic       is_space;
        logic       is_slash;
    } t_item;

    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hbf;

    // code point passes: no C0/C1 control, no DEL, no line or paragraph separator
    function automatic logic point_allowed(input logic [20:0] cp);
        logic ok;
        ok = 1'b1;
        if (cp <= 21'h1f) ok = 1'b0;
        if (cp >= 21'h7f && cp <= 21'h9f) ok = 1'b0;
        if (cp == 21'h2028 || cp == 21'h2029) ok = 1'b0;
        return ok;
    endfunction

endpackage

// File: rtl/sulc_front.sv
// Front end: takes input bytes and classifies each one for the decoder.
// Depends on sulc_pkg; pushes into sulc_queue.
module sulc_front (
    input  logic             i_valid,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic             i_empty_text,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output sulc_pkg::t_item  o_item
);

    logic [7:0] b;
    assign b = i_text_byte;

    // the queue is the only thing that can hold the front back
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // byte classification
    always_comb begin
        o_item             = '0;
        o_item.text_byte   = b;
        o_item.end_of_text = i_end_of_text;
        o_item.empty_text  = i_empty_text;
        o_item.ascii_ctrl  = (b <= 8'h1f) || (b == 8'h7f);
        o_item.is_space    = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
        o_item.is_slash    = (b == 8'h2f);
        o_item.kind        = sulc_pkg::KIND_BAD;
        o_item.lead_len    = 2'd0;
        o_item.lead_bits   = 5'd0;
        o_item.range       = sulc_pkg::RNG_FULL;
        if (b <= 8'h7f) begin
            o_item.kind = sulc_pkg::KIND_ASCII;
        end else if (b >= 8'hc2 && b <= 8'hdf) begin
            o_item.kind      = sulc_pkg::KIND_LEAD;
            o_item.lead_len  = 2'd1;
            o_item.lead_bits = b[4:0];
        end else if (b >= 8'he0 && b <= 8'hef) begin
            o_item.kind      = sulc_pkg::KIND_LEAD;
            o_item.lead_len  = 2'd2;
            o_item.lead_bits = {1'b0, b[3:0]};
        end else if (b >= 8'hf0 && b <= 8'hf4) begin
            o_item.kind      = sulc_pkg::KIND_LEAD;
            o_item.lead_len  = 2'd3;
            o_item.lead_bits = {2'b00, b[2:0]};
        end
        // tightened second-byte ranges
        case (b)
            8'he0:   o_item.range = sulc_pkg::RNG_E0;
            8'hed:   o_item.range = sulc_pkg::RNG_ED;
            8'hf0:   o_item.range = sulc_pkg::RNG_F0;
            8'hf4:   o_item.range = sulc_pkg::RNG_F4;
            default: o_item.range = sulc_pkg::RNG_FULL;
        endcase
    end

endmodule

// File: rtl/sulc_queue.sv
// Short register queue between the classifying front and the decoding back.
// Depends on sulc_pkg for the item type.
module sulc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sulc_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output sulc_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    sulc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr_ptr] <= i_item;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            if (pop_ok)  r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            if (push_ok && !pop_ok)      r_count <= r_count + 1'b1;
            else if (pop_ok && !push_ok) r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: rtl/sulc_back.sv
// Back end: decodes classified bytes, keeps the first error, issues one verdict per text.
// Depends on sulc_pkg; pops from sulc_queue and drives the result register.
module sulc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_mode,
    input  logic            i_q_valid,
    input  sulc_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_text_ok,
    output logic [2:0]      o_error_kind
);

    // per-text decode state
    logic [1:0]       r_pending, n_pending;
    logic [1:0]       r_pos, n_pos;
    sulc_pkg::t_range r_range, n_range;
    logic [20:0]      r_cp, n_cp;
    sulc_pkg::t_err   r_err, n_err;
    logic             r_saw_any, n_saw_any;
    logic             r_slash, n_slash;
    logic             r_space, n_space;

    // result register
    logic             r_out_valid;
    logic             r_out_ok;
    sulc_pkg::t_err   r_out_err;

    logic             item_final, take;
    logic [7:0]       b;
    logic [7:0]       lo, hi;
    sulc_pkg::t_err   verdict;

    assign b          = i_item.text_byte;
    assign item_final = i_item.empty_text || i_item.end_of_text;
    // a closing item needs the result register free; other items always go
    assign take       = i_q_valid && (!item_final || !r_out_valid || !i_stall);
    assign o_pop      = take;

    // continuation range for the current byte
    always_comb begin
        lo = sulc_pkg::CONT_LO;
        hi = sulc_pkg::CONT_HI;
        if (r_pos == 2'd0) begin
            case (r_range)
                sulc_pkg::RNG_E0: lo = 8'ha0;
                sulc_pkg::RNG_ED: hi = 8'h9f;
                sulc_pkg::RNG_F0: lo = 8'h90;
                sulc_pkg::RNG_F4: hi = 8'h8f;
                default: ;
            endcase
        end
    end

    // next decode state for one byte
    always_comb begin
        n_pending = r_pending;
        n_pos     = r_pos;
        n_range   = r_range;
        n_cp      = r_cp;
        n_err     = r_err;
        n_saw_any = r_saw_any;
        n_slash   = r_slash;
        n_space   = r_space;
        if (!i_item.empty_text) begin
            if (!r_saw_any) n_slash = i_item.is_slash;
            n_saw_any = 1'b1;
            if (i_item.is_space) n_space = 1'b1;
            if (r_err == sulc_pkg::ERR_NONE) begin
                if (r_pending == 2'd0) begin
                    n_range = i_item.range;
                    n_pos   = 2'd0;
                    case (i_item.kind)
                        sulc_pkg::KIND_ASCII: begin
                            if (i_item.ascii_ctrl) n_err = sulc_pkg::ERR_CONTROL;
                        end
                        sulc_pkg::KIND_LEAD: begin
                            n_cp      = {16'd0, i_item.lead_bits};
                            n_pending = i_item.lead_len;
                        end
                        default: n_err = sulc_pkg::ERR_MALFORMED;
                    endcase
                end else if (b < lo || b > hi) begin
                    n_err     = sulc_pkg::ERR_MALFORMED;
                    n_pending = 2'd0;
                end else begin
                    n_cp      = {r_cp[14:0], b[5:0]};
                    n_pos     = r_pos + 2'd1;
                    n_pending = r_pending - 2'd1;
                    if (n_pending == 2'd0 && !sulc_pkg::point_allowed(n_cp))
                        n_err = sulc_pkg::ERR_CONTROL;
                end
            end
        end
    end

    // verdict once the text closes
    always_comb begin
        verdict = n_err;
        if (!n_saw_any) begin
            verdict = sulc_pkg::ERR_EMPTY;
        end else begin
            if (verdict == sulc_pkg::ERR_NONE && n_pending != 2'd0)
                verdict = sulc_pkg::ERR_MALFORMED;
            if (verdict == sulc_pkg::ERR_NONE && i_mode == sulc_pkg::MODE_TOKEN && n_space)
                verdict = sulc_pkg::ERR_SPACE;
            if (verdict == sulc_pkg::ERR_NONE && i_mode == sulc_pkg::MODE_PATH && !n_slash)
                verdict = sulc_pkg::ERR_RELATIVE;
        end
    end

    // decode state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_pos     <= 2'd0;
            r_range   <= sulc_pkg::RNG_FULL;
            r_cp      <= '0;
            r_err     <= sulc_pkg::ERR_NONE;
            r_saw_any <= 1'b0;
            r_slash   <= 1'b0;
            r_space   <= 1'b0;
        end else if (take) begin
            if (item_final) begin
                r_pending <= 2'd0;
                r_pos     <= 2'd0;
                r_range   <= sulc_pkg::RNG_FULL;
                r_cp      <= '0;
                r_err     <= sulc_pkg::ERR_NONE;
                r_saw_any <= 1'b0;
                r_slash   <= 1'b0;
                r_space   <= 1'b0;
            end else begin
                r_pending <= n_pending;
                r_pos     <= n_pos;
                r_range   <= n_range;
                r_cp      <= n_cp;
                r_err     <= n_err;
                r_saw_any <= n_saw_any;
                r_slash   <= n_slash;
                r_space   <= n_space;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && item_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && item_final) begin
            r_out_ok  <= (verdict == sulc_pkg::ERR_NONE);
            r_out_err <= verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_text_ok    = r_out_ok;
    assign o_error_kind = r_out_err;

    // an open sequence implies a byte was seen and no error is held
    a_pending_saw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) |-> r_saw_any)
        else $error("open sequence without any byte");

    a_pending_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) |-> (r_err == sulc_pkg::ERR_NONE))
        else $error("sequence still open after an error");

    // errors only come from bytes
    a_err_saw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != sulc_pkg::ERR_NONE) |-> r_saw_any)
        else $error("error held with no byte seen");

    // verdict flag agrees with its code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ok == (r_out_err == sulc_pkg::ERR_NONE)))
        else $error("text_ok disagrees with error_kind");

    // a held result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_err)))
        else $error("stalled verdict changed");

endmodule

// File: rtl/strict_utf8_single_line_checker.sv
// Top level of the strict single-line UTF-8 checker.
// Depends on sulc_pkg, sulc_front, sulc_queue and sulc_back.
//
// Usage
//   Input channel: one byte per item (i_text_byte) with i_end_of_text on the
//   last byte, or an item with i_empty_text set that closes the text without
//   a byte. Taken when i_valid is high and o_stall is low.
//   Output channel: one verdict per text (o_text_ok, o_error_kind), taken
//   when o_valid is high and i_stall is low. Nothing comes out for other bytes.
//   Config: APB register 0 at address 0 holds check_mode (0 plain, 1 token,
//   2 absolute path, 3 as plain); write it only while no text is in flight.
//   Throughput: one byte per cycle while o_stall is low. The classifier feeds
//   a QUEUE_DEPTH-entry queue; the decoder pops one entry per cycle (see Stall).
//   Verdict path: an accepted closing item is written into the queue, then the
//   decoder writes its verdict into the result register that drives the output.
//   Stall: while a verdict waits, the decoder keeps taking bytes that do not
//   close a text; the next closing item waits in the queue, and o_stall rises
//   once the queue fills.
//   Reset: synchronous active low; clears the queue, the decode state, the
//   result valid and check_mode.
module strict_utf8_single_line_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_empty_text,
    // verdict output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_text_ok,
    output logic [2:0]  o_error_kind,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sulc_pkg::t_item front_item, back_item;
    logic            push, q_full, q_valid, pop;
    logic [1:0]      r_mode;

    // mode register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sulc_pkg::MODE_PLAIN;
        end else if (psel && penable && pwrite && paddr == sulc_pkg::ADDR_CHECK_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign prdata = (paddr == sulc_pkg::ADDR_CHECK_MODE) ? {30'd0, r_mode} : 32'd0;

    sulc_front u_front (
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_empty_text  (i_empty_text),
        .i_q_full      (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_item        (front_item)
    );

    sulc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (back_item)
    );

    sulc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_q_valid    (q_valid),
        .i_item       (back_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_text_ok    (o_text_ok),
        .o_error_kind (o_error_kind)
    );

endmodule

// File: verif/strict_utf8_single_line_checker_test.sv
// Self-checking testbench for strict_utf8_single_line_checker.
// Streams directed and random texts, predicts each verdict in step and checks it.
// Depends on sulc_pkg and the strict_utf8_single_line_checker RTL.
module strict_utf8_single_line_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam int         DRAIN_CYCLES    = 12;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic           ok;
        sulc_pkg::t_err kind;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_text_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        i_empty_text  = 1'b0;
    logic        i_stall       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [1:0]  paddr         = 2'd0;
    logic [31:0] pwdata        = 32'd0;
    logic        o_stall;
    logic        o_valid;
    logic        o_text_ok;
    logic [2:0]  o_error_kind;
    logic [31:0] prdata;
    logic        pready;

    strict_utf8_single_line_checker u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .i_empty_text (i_empty_text),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_text_ok    (o_text_ok),
        .o_error_kind (o_error_kind),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predicted decoder state
    logic [1:0]     mode_model;
    logic [1:0]     pend_cnt;
    logic [7:0]     lead_byte;
    logic [1:0]     cont_idx;
    logic [20:0]    code_acc;
    sulc_pkg::t_err kept_err;
    logic           any_byte;
    logic           slash_first;
    logic           space_seen;

    t_verdict verdict_q[$];
    int       fail_count = 0;
    int       send_idle  = 0;
    int       recv_idle  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("strict_utf8_single_line_checker_test: errors");
        $finish;
    end

    function automatic logic code_point_ok(input logic [20:0] cp);
        if (cp <= 21'h1f) return 1'b0;
        if (cp >= 21'h7f && cp <= 21'h9f) return 1'b0;
        if (cp == 21'h2028 || cp == 21'h2029) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_text_state();
        pend_cnt    = 2'd0;
        lead_byte   = 8'h00;
        cont_idx    = 2'd0;
        code_acc    = 21'd0;
        kept_err    = sulc_pkg::ERR_NONE;
        any_byte    = 1'b0;
        slash_first = 1'b0;
        space_seen  = 1'b0;
    endfunction

    // decode one byte into the predicted state
    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = sulc_pkg::CONT_LO;
        hi = sulc_pkg::CONT_HI;
        if (!any_byte) slash_first = (b == 8'h2f);
        any_byte = 1'b1;
        if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d)) space_seen = 1'b1;
        if (kept_err != sulc_pkg::ERR_NONE) return;
        if (pend_cnt == 2'd0) begin
            lead_byte = b;
            cont_idx  = 2'd0;
            if (b <= 8'h7f) begin
                if (!code_point_ok({13'd0, b})) kept_err = sulc_pkg::ERR_CONTROL;
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
                code_acc = {16'd0, b[4:0]};
                pend_cnt = 2'd1;
            end else if (b >= 8'he0 && b <= 8'hef) begin
                code_acc = {17'd0, b[3:0]};
                pend_cnt = 2'd2;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
                code_acc = {18'd0, b[2:0]};
                pend_cnt = 2'd3;
            end else begin
                kept_err = sulc_pkg::ERR_MALFORMED;
            end
            return;
        end
        // narrowed range on the first continuation byte
        if (cont_idx == 2'd0) begin
            if (lead_byte == 8'he0) lo = 8'ha0;
            else if (lead_byte == 8'hed) hi = 8'h9f;
            else if (lead_byte == 8'hf0) lo = 8'h90;
            else if (lead_byte == 8'hf4) hi = 8'h8f;
        end
        if (b < lo || b > hi) begin
            kept_err = sulc_pkg::ERR_MALFORMED;
            pend_cnt = 2'd0;
            return;
        end
        code_acc = {code_acc[14:0], b[5:0]};
        cont_idx = cont_idx + 2'd1;
        pend_cnt = pend_cnt - 2'd1;
        if (pend_cnt == 2'd0 && !code_point_ok(code_acc)) kept_err = sulc_pkg::ERR_CONTROL;
    endfunction

    // fold one item into the prediction, queue a verdict when a text closes
    function automatic void predict_item(input logic [7:0] b, input logic eot,
                                         input logic emp);
        t_verdict       v;
        sulc_pkg::t_err e;
        if (!emp) begin
            predict_byte(b);
            if (!eot) return;
        end
        e = kept_err;
        if (!any_byte) begin
            e = sulc_pkg::ERR_EMPTY;
        end else begin
            if (e == sulc_pkg::ERR_NONE && pend_cnt != 2'd0) e = sulc_pkg::ERR_MALFORMED;
            if (e == sulc_pkg::ERR_NONE && mode_model == sulc_pkg::MODE_TOKEN && space_seen)
                e = sulc_pkg::ERR_SPACE;
            if (e == sulc_pkg::ERR_NONE && mode_model == sulc_pkg::MODE_PATH && !slash_first)
                e = sulc_pkg::ERR_RELATIVE;
        end
        v.ok   = (e == sulc_pkg::ERR_NONE);
        v.kind = e;
        verdict_q.push_back(v);
        clear_text_state();
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    // compare each accepted verdict with the oldest prediction
    always @(posedge i_clk) begin : check_verdicts
        t_verdict exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict: text_ok %0d error_kind %0d",
                       o_text_ok, o_error_kind);
                fail_count++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_text_ok !== exp_v.ok) begin
                    $error("text_ok: expected %0d, got %0d", exp_v.ok, o_text_ok);
                    fail_count++;
                end
                if (o_error_kind !== exp_v.kind) begin
                    $error("error_kind: expected %0d, got %0d", exp_v.kind, o_error_kind);
                    fail_count++;
                end
            end
        end
    end

    // present one item, return at the edge that takes it; valid stays high
    task automatic send_item(input logic [7:0] b, input logic eot, input logic emp);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        i_empty_text  <= emp;
        predict_item(b, eot, emp);
        do @(posedge i_clk); while (o_stall);
    endtask

    // bytes of one text, end mark on the last one
    task automatic send_text(input t_byte_q bytes);
        foreach (bytes[k]) send_item(bytes[k], (k == bytes.size() - 1), 1'b0);
    endtask

    // drop valid and wait until every verdict is in and the queue has drained
    task automatic settle();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write of check_mode, then read it back
    task automatic write_check_mode(input logic [1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sulc_pkg::ADDR_CHECK_MODE;
        pwdata  <= {30'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mode_model = mode;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== mode) begin
            $error("check_mode: expected %0d, got %0d", mode, prdata[1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // append the utf-8 encoding of one code point
    task automatic encode_point(inout t_byte_q q, input logic [20:0] cp);
        if (cp < 21'h80) begin
            q.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            q.push_back({3'b110, cp[10:6]});
            q.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            q.push_back({4'b1110, cp[15:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
        end else begin
            q.push_back({5'b11110, cp[20:18]});
            q.push_back({2'b10, cp[17:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
        end
    endtask

    // one random text, mostly well formed; returns items sent
    task automatic send_random_text(output int n_items);
        t_byte_q bytes;
        int      units;
        int      r;
        bytes   = {};
        n_items = 0;
        if ($urandom_range(99) < 8) begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            n_items = 1;
            return;
        end
        units = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
        if (mode_model == sulc_pkg::MODE_PATH && $urandom_range(99) < 80) bytes.push_back(8'h2f);
        repeat (units) begin
            r = $urandom_range(99);
            if (r < 40) encode_point(bytes, 21'($urandom_range(8'h7e, 8'h20)));
            else if (r < 45) encode_point(bytes, ($urandom_range(1) != 0) ? 21'h20 : 21'h2f);
            else if (r < 60) encode_point(bytes, 21'($urandom_range(21'h7ff, 21'h80)));
            else if (r < 75) encode_point(bytes, 21'($urandom_range(21'hffff, 21'h800)));
            else if (r < 78) encode_point(bytes, 21'h2028 + 21'($urandom_range(1)));
            else if (r < 88) encode_point(bytes, 21'($urandom_range(21'h10ffff, 21'h10000)));
            else if (r < 95) bytes.push_back(8'($urandom_range(255)));
            else bytes.push_back(8'($urandom_range(8'hf4, 8'hc2)));
        end
        if ($urandom_range(99) < 85) begin
            send_text(bytes);
            n_items = bytes.size();
        end else begin
            // close with an empty mark after the bytes
            foreach (bytes[k]) send_item(bytes[k], 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            n_items = bytes.size() + 1;
        end
    endtask

    // code point ranges, lead narrowing, controls, marks and each mode
    task automatic test_directed_cases();
        send_idle = 0;
        recv_idle = 0;
        write_check_mode(sulc_pkg::MODE_PLAIN);
        send_item(8'h00, 1'b0, 1'b1);
        send_text('{8'h00});
        send_text('{8'hff});
        send_text('{8'hc2, 8'h80});
        send_text('{8'he2, 8'h80, 8'ha8});
        send_text('{8'he0, 8'h9f});
        send_text('{8'hed, 8'ha0});
        send_text('{8'hf0, 8'h8f});
        send_text('{8'hf4, 8'h90});
        send_text('{8'hf4, 8'h8f, 8'hbf, 8'hbf});
        // cut-off sequence
        send_text('{8'hc2});
        // empty mark after a byte, then both marks on one item
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h41, 1'b1, 1'b1);
        settle();
        write_check_mode(sulc_pkg::MODE_TOKEN);
        send_text('{8'h20});
        send_text('{8'h09});
        send_text('{8'h41});
        settle();
        write_check_mode(sulc_pkg::MODE_PATH);
        send_text('{8'h41});
        send_text('{8'h2f, 8'h41});
        settle();
        write_check_mode(MODE_SPARE);
        send_text('{8'h20});
        settle();
    endtask

    // random texts through every mode at one idling setting
    task automatic test_random_texts(input int s_idle, input int r_idle, input int n_items);
        logic [1:0] modes[4];
        int         sent;
        int         n;
        modes     = '{sulc_pkg::MODE_PLAIN, sulc_pkg::MODE_TOKEN, sulc_pkg::MODE_PATH,
                      MODE_SPARE};
        send_idle = s_idle;
        recv_idle = r_idle;
        foreach (modes[m]) begin
            write_check_mode(modes[m]);
            sent = 0;
            while (sent < n_items / 4) begin
                send_random_text(n);
                sent += n;
            end
            settle();
        end
    endtask

    initial begin
        clear_text_state();
        mode_model = sulc_pkg::MODE_PLAIN;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_texts(29, 61, 300);
        test_random_texts(61, 29, 300);
        test_random_texts(0, 0, 300);

        settle();
        if (verdict_q.size() != 0) begin
            $error("%0d verdicts never arrived", verdict_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("strict_utf8_single_line_checker_test: clean");
        end else begin
            $display("strict_utf8_single_line_checker_test: errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sulc_pkg.sv
rtl/sulc_front.sv
rtl/sulc_queue.sv
rtl/sulc_back.sv
rtl/strict_utf8_single_line_checker.sv
verif/strict_utf8_single_line_checker_test.sv
